@@ sv/afl_pkg.sv @@
// shared types, codes and constants of the aligned free list heap allocator
package afl_pkg;

  localparam int DATA_W         = 16;
  localparam int CFG_W          = 13;
  localparam int STATUS_W       = 3;
  localparam int KIND_W         = 2;
  localparam int CELL_BYTES     = 16;
  localparam int CELL_SHIFT     = 4;
  localparam int N_W            = 13;
  localparam int AL_W           = 12;
  localparam int HEAP_CELLS_DEF = 4096;
  localparam int CFG_RESET      = 4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPTR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BROKEN = 3'd4;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] size_bytes;
    logic [DATA_W-1:0] align_bytes;
    logic [DATA_W-1:0] free_addr;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   block_addr;
    logic [STATUS_W-1:0] status;
  } out_t;

endpackage

@@ sv/afl_ram.sv @@
// generic single write port ram with registered read
module afl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/afl_alu.sv @@
// shared add and compare unit: checks a + b against c
module afl_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] c,
  output logic         gt,
  output logic         eq
);

  logic [W-1:0] sum;

  assign sum = a + b;
  assign gt  = (sum > c);
  assign eq  = (sum == c);

endmodule

@@ sv/aligned_free_list_heap_allocator_unit.sv @@
// top level of the aligned free list heap allocator: sequencer, cell stores and shared alu
`default_nettype none
// A transaction is taken when start is high and busy is low; busy then stays high until the
// result has been produced, and the result appears on out_data for exactly one cycle with
// out_valid high. The receiver cannot hold it off. One add and compare unit and one read of
// the cell stores per step set the timing: an allocate checks the free start, visits each
// free block on the ring (head, examine, fit), splits (with a link step when a free remainder
// stays after it) and marks it allocated; a free checks pointer and header, walks the ring
// headers (head, examine), then inserts and merges. After reset and every heap_cells write,
// busy stays high sweeping all HEAP_CELLS cells to rebuild the heap as one free block.
module aligned_free_list_heap_allocator_unit #(
  parameter int HEAP_CELLS = afl_pkg::HEAP_CELLS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire afl_pkg::in_t             in_data,
  output logic                          out_valid,
  output afl_pkg::out_t                 out_data,
  input  wire logic                     cfg_we,
  input  wire logic [afl_pkg::CFG_W-1:0] cfg_wdata
);

  import afl_pkg::*;

  localparam int IDX_W = $clog2(HEAP_CELLS);
  localparam int SZ_W  = $clog2(HEAP_CELLS + 1);
  localparam int AW    = ((SZ_W > 14) ? SZ_W : 14) + 1;
  localparam int RST_CELLS = (HEAP_CELLS < CFG_RESET) ? HEAP_CELLS : CFG_RESET;
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(HEAP_CELLS - 1);
  localparam logic [AW-1:0]    HEAP_AW   = AW'(HEAP_CELLS);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR      = 5'd1;
  localparam logic [4:0] S_AL_CHK   = 5'd2;
  localparam logic [4:0] S_AL_FIRST = 5'd3;
  localparam logic [4:0] S_AL_HEAD  = 5'd4;
  localparam logic [4:0] S_AL_EXAM  = 5'd5;
  localparam logic [4:0] S_AL_FIT   = 5'd6;
  localparam logic [4:0] S_AL_SPLIT = 5'd7;
  localparam logic [4:0] S_AL_LINK  = 5'd8;
  localparam logic [4:0] S_AL_DONE  = 5'd9;
  localparam logic [4:0] S_FR_CHK   = 5'd10;
  localparam logic [4:0] S_FR_HDR   = 5'd11;
  localparam logic [4:0] S_FR_START = 5'd12;
  localparam logic [4:0] S_FR_HEAD  = 5'd13;
  localparam logic [4:0] S_FR_EXAM  = 5'd14;
  localparam logic [4:0] S_FR_INS   = 5'd15;
  localparam logic [4:0] S_FR_LO    = 5'd16;
  localparam logic [4:0] S_FR_HI    = 5'd17;

  function automatic logic [AL_W-1:0] msb_only(input logic [AL_W-1:0] v);
    logic [AL_W-1:0] m;
    m = v | (v >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m ^ (m >> 1);
  endfunction

  logic [4:0]         state_r, state_nxt;
  logic [SZ_W-1:0]    heap_r, heap_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [IDX_W-1:0]   fs_r, fs_nxt;
  logic [N_W-1:0]     n_r, n_nxt;
  logic [AL_W-1:0]    al_r, al_nxt;
  logic [N_W-1:0]     cell_r, cell_nxt;
  logic               misal_r, misal_nxt;
  logic [IDX_W-1:0]   first_r, first_nxt;
  logic [IDX_W-1:0]   p_r, p_nxt;
  logic [IDX_W-1:0]   q_r, q_nxt;
  logic [IDX_W-1:0]   s_r, s_nxt;
  logic [IDX_W-1:0]   np_r, np_nxt;
  logic [IDX_W-1:0]   rc_r, rc_nxt;
  logic [SZ_W:0]      steps_r, steps_nxt;
  logic [SZ_W-1:0]    sz_r, sz_nxt;
  logic [SZ_W-1:0]    szq_r, szq_nxt;
  logic [AL_W-1:0]    extra_r, extra_nxt;
  logic [SZ_W-1:0]    ex2_r, ex2_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               kd_we, sz_we, nx_we;
  logic [IDX_W-1:0]   kd_wa, sz_wa, nx_wa, raddr;
  logic [KIND_W-1:0]  kd_wd, rd_kind;
  logic [SZ_W-1:0]    sz_wd, rd_size;
  logic [IDX_W-1:0]   nx_wd, rd_next;

  logic [AW-1:0]      alu_a, alu_b, alu_c;
  logic               alu_gt, alu_eq;

  logic [N_W-1:0]     in_n, in_cell;
  logic [AL_W-1:0]    in_al_raw;
  logic [AW-1:0]      in_cell_m1, p_plus1, rem, ex2_w, p_ex2, r_w, rsz_w;
  logic [AW-1:0]      lo_sum, hi_sum, cfg_aw, heap_aw;
  logic [AL_W-1:0]    al_m1, pm, ext;
  logic [SZ_W:0]      steps_inc;
  logic [DATA_W-1:0]  blk_addr;

  afl_ram #(.WIDTH(KIND_W), .DEPTH(HEAP_CELLS)) u_kind_ram (
    .clk(clk), .we(kd_we), .waddr(kd_wa), .wdata(kd_wd), .raddr(raddr), .rdata(rd_kind)
  );

  afl_ram #(.WIDTH(SZ_W), .DEPTH(HEAP_CELLS)) u_size_ram (
    .clk(clk), .we(sz_we), .waddr(sz_wa), .wdata(sz_wd), .raddr(raddr), .rdata(rd_size)
  );

  afl_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_CELLS)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(raddr), .rdata(rd_next)
  );

  afl_alu #(.W(AW)) u_alu (
    .a(alu_a), .b(alu_b), .c(alu_c), .gt(alu_gt), .eq(alu_eq)
  );

  assign in_n = N_W'(in_data.size_bytes[DATA_W-1:CELL_SHIFT])
              + N_W'(|in_data.size_bytes[CELL_SHIFT-1:0]) + N_W'(1);
  assign in_al_raw  = in_data.align_bytes[DATA_W-1:CELL_SHIFT];
  assign in_cell    = {(in_data.free_addr == '0), in_data.free_addr[DATA_W-1:CELL_SHIFT]};
  assign in_cell_m1 = AW'(in_cell) - AW'(1);

  assign heap_aw   = AW'(heap_r);
  assign p_plus1   = AW'(p_r) + AW'(1);
  assign al_m1     = al_r - AL_W'(1);
  assign pm        = p_plus1[AL_W-1:0] & al_m1;
  assign ext       = (pm == '0) ? '0 : (al_r - pm);
  assign rem       = AW'(sz_r) - AW'(n_r) - AW'(extra_r);
  assign ex2_w     = AW'(extra_r) + (rem & ~AW'(al_m1));
  assign p_ex2     = AW'(p_r) + AW'(ex2_r);
  assign r_w       = p_ex2 + AW'(n_r);
  assign rsz_w     = AW'(sz_r) - AW'(ex2_r) - AW'(n_r);
  assign lo_sum    = AW'(rd_size) + AW'(sz_r);
  assign hi_sum    = AW'(sz_r) + AW'(szq_r);
  assign steps_inc = steps_r + (SZ_W+1)'(1);
  assign cfg_aw    = AW'(cfg_wdata);
  assign blk_addr  = {p_plus1[DATA_W-CELL_SHIFT-1:0], {CELL_SHIFT{1'b0}}};

  always_comb begin
    state_nxt     = state_r;
    heap_nxt      = heap_r;
    clr_nxt       = clr_r;
    fs_nxt        = fs_r;
    n_nxt         = n_r;
    al_nxt        = al_r;
    cell_nxt      = cell_r;
    misal_nxt     = misal_r;
    first_nxt     = first_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    s_nxt         = s_r;
    np_nxt        = np_r;
    rc_nxt        = rc_r;
    steps_nxt     = steps_r;
    sz_nxt        = sz_r;
    szq_nxt       = szq_r;
    extra_nxt     = extra_r;
    ex2_nxt       = ex2_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    kd_we = 1'b0; kd_wa = p_r; kd_wd = KIND_NONE;
    sz_we = 1'b0; sz_wa = p_r; sz_wd = '0;
    nx_we = 1'b0; nx_wa = p_r; nx_wd = '0;
    raddr = p_r;
    alu_a = '0; alu_b = '0; alu_c = heap_aw;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.cmd == CMD_ALLOC) begin
            n_nxt     = in_n;
            al_nxt    = msb_only((in_al_raw == '0) ? AL_W'(1) : in_al_raw);
            first_nxt = fs_r;
            state_nxt = S_AL_CHK;
          end else begin
            cell_nxt  = in_cell;
            misal_nxt = |in_data.free_addr[CELL_SHIFT-1:0];
            p_nxt     = in_cell_m1[IDX_W-1:0];
            state_nxt = S_FR_CHK;
          end
        end
      end
      S_CLR: begin
        kd_we = 1'b1; kd_wa = clr_r; kd_wd = (clr_r == '0) ? KIND_FREE : KIND_NONE;
        sz_we = 1'b1; sz_wa = clr_r; sz_wd = (clr_r == '0) ? heap_r : '0;
        nx_we = 1'b1; nx_wa = clr_r; nx_wd = '0;
        if (clr_r == LAST_CELL) begin
          fs_nxt    = '0;
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end
      S_AL_CHK: begin
        raddr = first_r;
        alu_a = AW'(first_r); alu_b = AW'(1);
        if (alu_gt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BROKEN};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_AL_FIRST;
        end
      end
      S_AL_FIRST: begin
        if (rd_kind == KIND_ALLOC) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_OOM};
          state_nxt     = S_IDLE;
        end else begin
          q_nxt     = first_r;
          p_nxt     = rd_next;
          steps_nxt = '0;
          state_nxt = S_AL_HEAD;
        end
      end
      S_AL_HEAD: begin
        raddr = p_r;
        alu_a = AW'(steps_r);
        if (alu_gt || (AW'(p_r) >= heap_aw)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BROKEN};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_AL_EXAM;
        end
      end
      S_AL_EXAM: begin
        alu_a = AW'(p_r); alu_b = AW'(rd_size);
        if ((rd_kind != KIND_FREE) || alu_gt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BROKEN};
          state_nxt     = S_IDLE;
        end else begin
          sz_nxt    = rd_size;
          np_nxt    = rd_next;
          extra_nxt = ext;
          state_nxt = S_AL_FIT;
        end
      end
      S_AL_FIT: begin
        alu_a = AW'(n_r); alu_b = AW'(extra_r); alu_c = AW'(sz_r);
        if (!alu_gt) begin
          ex2_nxt   = ex2_w[SZ_W-1:0];
          state_nxt = S_AL_SPLIT;
        end else if (p_r == first_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_OOM};
          state_nxt     = S_IDLE;
        end else begin
          q_nxt     = p_r;
          p_nxt     = np_r;
          steps_nxt = steps_inc;
          state_nxt = S_AL_HEAD;
        end
      end
      S_AL_SPLIT: begin
        alu_a = AW'(n_r); alu_b = AW'(ex2_r); alu_c = AW'(sz_r);
        if ((ex2_r == '0) && (AW'(sz_r) == AW'(n_r))) begin
          nx_we = 1'b1; nx_wa = q_r; nx_wd = np_r;
          state_nxt = S_AL_DONE;
        end else if ((al_r == AL_W'(1)) || alu_eq) begin
          sz_we = 1'b1; sz_wa = p_r; sz_wd = ex2_r;
          p_nxt     = p_ex2[IDX_W-1:0];
          state_nxt = S_AL_DONE;
        end else begin
          kd_we = 1'b1; kd_wa = r_w[IDX_W-1:0]; kd_wd = KIND_FREE;
          sz_we = 1'b1; sz_wa = r_w[IDX_W-1:0]; sz_wd = rsz_w[SZ_W-1:0];
          nx_we = 1'b1; nx_wa = q_r;            nx_wd = r_w[IDX_W-1:0];
          rc_nxt    = r_w[IDX_W-1:0];
          state_nxt = S_AL_LINK;
        end
      end
      S_AL_LINK: begin
        nx_we = 1'b1; nx_wa = rc_r;
        if (ex2_r == '0) begin
          if (q_r == p_r) begin
            nx_wd = rc_r;
            q_nxt = rc_r;
          end else begin
            nx_wd = np_r;
          end
        end else begin
          nx_wd = p_r;
          sz_we = 1'b1; sz_wa = p_r; sz_wd = ex2_r;
          p_nxt = p_ex2[IDX_W-1:0];
        end
        state_nxt = S_AL_DONE;
      end
      S_AL_DONE: begin
        kd_we = 1'b1; kd_wa = p_r; kd_wd = KIND_ALLOC;
        sz_we = 1'b1; sz_wa = p_r; sz_wd = SZ_W'(AW'(n_r));
        fs_nxt        = q_r;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{block_addr: blk_addr, status: ST_OK};
        state_nxt     = S_IDLE;
      end
      S_FR_CHK: begin
        raddr = p_r;
        alu_a = AW'(cell_r);
        if (misal_r || alu_gt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BADPTR};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_FR_HDR;
        end
      end
      S_FR_HDR: begin
        raddr = fs_r;
        alu_a = AW'(fs_r); alu_b = AW'(1);
        if (rd_kind == KIND_FREE) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_DOUBLE};
          state_nxt     = S_IDLE;
        end else if ((rd_kind != KIND_ALLOC) || alu_gt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BROKEN};
          state_nxt     = S_IDLE;
        end else begin
          sz_nxt    = rd_size;
          state_nxt = S_FR_START;
        end
      end
      S_FR_START: begin
        if (rd_kind == KIND_ALLOC) begin
          kd_we = 1'b1; kd_wa = p_r; kd_wd = KIND_FREE;
          nx_we = 1'b1; nx_wa = p_r; nx_wd = p_r;
          fs_nxt        = p_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_OK};
          state_nxt     = S_IDLE;
        end else begin
          s_nxt     = fs_r;
          q_nxt     = rd_next;
          steps_nxt = '0;
          state_nxt = S_FR_HEAD;
        end
      end
      S_FR_HEAD: begin
        raddr = q_r;
        alu_a = AW'(q_r); alu_b = AW'(1);
        if (alu_gt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BROKEN};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_FR_EXAM;
        end
      end
      S_FR_EXAM: begin
        alu_a = AW'(steps_r); alu_b = AW'(1);
        if (AW'(rd_next) >= heap_aw) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BROKEN};
          state_nxt     = S_IDLE;
        end else if (!((q_r <= p_r) || (rd_next >= p_r)) ||
                     ((rd_kind == KIND_FREE) && (q_r <= rd_next) &&
                      ((q_r > p_r) || (rd_next < p_r)))) begin
          np_nxt    = rd_next;
          szq_nxt   = rd_size;
          state_nxt = S_FR_INS;
        end else if ((rd_kind != KIND_FREE) || alu_gt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_addr: '0, status: ST_BROKEN};
          state_nxt     = S_IDLE;
        end else begin
          s_nxt     = q_r;
          q_nxt     = rd_next;
          steps_nxt = steps_inc;
          state_nxt = S_FR_HEAD;
        end
      end
      S_FR_INS: begin
        raddr = np_r;
        kd_we = 1'b1; kd_wa = p_r; kd_wd = KIND_FREE;
        nx_we = 1'b1; nx_wa = p_r; nx_wd = np_r;
        state_nxt = S_FR_LO;
      end
      S_FR_LO: begin
        alu_a = AW'(np_r); alu_b = AW'(rd_size); alu_c = AW'(p_r);
        nx_we = 1'b1; nx_wa = q_r;
        if (alu_eq) begin
          nx_wd = np_r;
          kd_we = 1'b1; kd_wa = p_r; kd_wd = KIND_NONE;
          sz_we = 1'b1; sz_wa = np_r; sz_wd = lo_sum[SZ_W-1:0];
          p_nxt  = np_r;
          sz_nxt = lo_sum[SZ_W-1:0];
          if (q_r == np_r) begin
            szq_nxt = lo_sum[SZ_W-1:0];
          end
        end else begin
          nx_wd = p_r;
        end
        state_nxt = S_FR_HI;
      end
      S_FR_HI: begin
        alu_a = AW'(p_r); alu_b = AW'(sz_r); alu_c = AW'(q_r);
        if (alu_eq) begin
          kd_we = 1'b1; kd_wa = q_r; kd_wd = KIND_NONE;
          sz_we = 1'b1; sz_wa = p_r; sz_wd = hi_sum[SZ_W-1:0];
          nx_we = 1'b1; nx_wa = (q_r == s_r) ? p_r : s_r; nx_wd = p_r;
          fs_nxt = (q_r == s_r) ? p_r : s_r;
        end else begin
          fs_nxt = q_r;
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{block_addr: '0, status: ST_OK};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_aw < AW'(2)) begin
        heap_nxt = SZ_W'(2);
      end else if (cfg_aw > HEAP_AW) begin
        heap_nxt = SZ_W'(HEAP_CELLS);
      end else begin
        heap_nxt = cfg_aw[SZ_W-1:0];
      end
      clr_nxt   = '0;
      state_nxt = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      heap_r      <= SZ_W'(RST_CELLS);
      clr_r       <= '0;
      fs_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      heap_r      <= heap_nxt;
      clr_r       <= clr_nxt;
      fs_r        <= fs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    al_r       <= al_nxt;
    cell_r     <= cell_nxt;
    misal_r    <= misal_nxt;
    first_r    <= first_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    s_r        <= s_nxt;
    np_r       <= np_nxt;
    rc_r       <= rc_nxt;
    steps_r    <= steps_nxt;
    sz_r       <= sz_nxt;
    szq_r      <= szq_nxt;
    extra_r    <= extra_nxt;
    ex2_r      <= ex2_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) != S_IDLE) && ($past(state_r) != S_CLR))
    else $error("result without a transaction in progress");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.block_addr == '0))
    else $error("failed transaction returned an address");
`endif

endmodule
`default_nettype wire

@@ verif/tb_aligned_free_list_heap_allocator_unit.sv @@
// self-checking testbench of the aligned free list heap allocator with its heap model
module tb_aligned_free_list_heap_allocator_unit;
  import afl_pkg::*;

  class heap_scoreboard;
    int unsigned cell_kind[HEAP_CELLS_DEF];
    int unsigned cell_size[HEAP_CELLS_DEF];
    int unsigned cell_next[HEAP_CELLS_DEF];
    int unsigned free_start;
    int unsigned heap_cells;
    out_t expected_replies[$];
    int errors;
    int replies;
    int ok_allocs;
    int ok_frees;
    int rejects;

    function void rebuild(int unsigned cells);
      if (cells < 2) cells = 2;
      if (cells > HEAP_CELLS_DEF) cells = HEAP_CELLS_DEF;
      heap_cells = cells;
      for (int i = 0; i < HEAP_CELLS_DEF; i++) begin
        cell_kind[i] = KIND_NONE;
        cell_size[i] = 0;
        cell_next[i] = 0;
      end
      cell_kind[0] = KIND_FREE;
      cell_size[0] = cells;
      free_start = 0;
    endfunction

    function logic [STATUS_W-1:0] alloc_cells(int unsigned n, int unsigned al,
                                              output int unsigned hdr);
      int unsigned first, q, p, extra, sz, r;
      hdr = 0;
      first = free_start;
      if (first >= heap_cells) return ST_BROKEN;
      if (cell_kind[first] == KIND_ALLOC) return ST_OOM;
      q = first;
      p = cell_next[first];
      for (int unsigned steps = 0; steps <= heap_cells; steps++) begin
        if (p >= heap_cells) return ST_BROKEN;
        if (cell_kind[p] != KIND_FREE) return ST_BROKEN;
        sz = cell_size[p];
        if (sz > heap_cells - p) return ST_BROKEN;
        extra = (p + 1) % al;
        if (extra != 0) extra = al - extra;
        if (sz >= n + extra) begin
          extra += (sz - extra - n) & ~(al - 1);
          if (extra == 0 && sz == n) begin
            cell_next[q] = cell_next[p];
          end else if (al == 1 || sz == n + extra) begin
            cell_size[p] = sz - n;
            p += sz - n;
          end else begin
            r = p + extra + n;
            cell_kind[r] = KIND_FREE;
            cell_size[r] = sz - extra - n;
            cell_next[q] = r;
            if (extra == 0) begin
              cell_next[r] = cell_next[p];
              if (q == p) begin
                q = r;
                cell_next[r] = r;
              end
            end else begin
              cell_next[r] = p;
              cell_size[p] = extra;
              p += extra;
            end
          end
          cell_kind[p] = KIND_ALLOC;
          cell_size[p] = n;
          free_start = q;
          hdr = p;
          return ST_OK;
        end
        if (p == first) return ST_OOM;
        q = p;
        p = cell_next[p];
      end
      return ST_BROKEN;
    endfunction

    function logic [STATUS_W-1:0] release_block(int unsigned addr16);
      int unsigned full, hdr_cell, p, q, s, lo, steps;
      steps = 0;
      full = (addr16 == 0) ? 65536 : addr16;
      if (full % CELL_BYTES != 0) return ST_BADPTR;
      hdr_cell = full / CELL_BYTES;
      if (hdr_cell < 1 || hdr_cell > heap_cells) return ST_BADPTR;
      p = hdr_cell - 1;
      if (cell_kind[p] == KIND_FREE) return ST_DOUBLE;
      if (cell_kind[p] != KIND_ALLOC) return ST_BROKEN;
      if (free_start >= heap_cells) return ST_BROKEN;
      if (cell_kind[free_start] == KIND_ALLOC) begin
        cell_kind[p] = KIND_FREE;
        cell_next[p] = p;
        free_start = p;
        return ST_OK;
      end
      s = free_start;
      q = cell_next[s];
      forever begin
        if (q >= heap_cells || cell_next[q] >= heap_cells) return ST_BROKEN;
        if (!(q <= p || cell_next[q] >= p)) break;
        if (cell_kind[q] != KIND_FREE) return ST_BROKEN;
        if (q <= cell_next[q] && (q > p || cell_next[q] < p)) break;
        steps++;
        if (steps > heap_cells) return ST_BROKEN;
        s = q;
        q = cell_next[s];
      end
      cell_kind[p] = KIND_FREE;
      cell_next[p] = cell_next[q];
      cell_next[q] = p;
      lo = cell_next[p];
      if (lo + cell_size[lo] == p) begin
        cell_kind[p] = KIND_NONE;
        cell_size[lo] += cell_size[p];
        cell_next[q] = lo;
        p = lo;
      end
      if (q == p + cell_size[p]) begin
        cell_kind[q] = KIND_NONE;
        cell_size[p] += cell_size[q];
        if (q == s) s = p;
        cell_next[s] = p;
        q = s;
      end
      free_start = q;
      return ST_OK;
    endfunction

    function out_t note_request(in_t req);
      out_t rsp;
      int unsigned n, al, hdr;
      rsp.block_addr = '0;
      if (req.cmd == CMD_ALLOC) begin
        n = (int'(req.size_bytes) + CELL_BYTES - 1) / CELL_BYTES + 1;
        al = req.align_bytes / CELL_BYTES;
        if (al == 0) al = 1;
        while ((al & (al - 1)) != 0) al &= al - 1;
        rsp.status = alloc_cells(n, al, hdr);
        if (rsp.status == ST_OK) begin
          rsp.block_addr = 16'((hdr + 1) * CELL_BYTES);
          ok_allocs++;
        end
      end else begin
        rsp.status = release_block(req.free_addr);
        if (rsp.status == ST_OK) ok_frees++;
      end
      if (rsp.status != ST_OK) rejects++;
      expected_replies.push_back(rsp);
      return rsp;
    endfunction

    function void check_reply(out_t got);
      out_t want;
      replies++;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result addr=%h status=%0d", $time, got.block_addr,
                 got.status);
        return;
      end
      want = expected_replies.pop_front();
      if (got.block_addr !== want.block_addr) begin
        errors++;
        $display("%0t: block_addr expected %h actual %h", $time, want.block_addr,
                 got.block_addr);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  heap_scoreboard sb;
  logic [DATA_W-1:0] live_blocks[$];
  logic [DATA_W-1:0] freed_blocks[$];
  int n_items;
  int n_configs;
  bit no_gaps;

  aligned_free_list_heap_allocator_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_reply(out_data);
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(in_t req);
    out_t rsp;
    int gap;
    in_data <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    rsp = sb.note_request(req);
    n_items++;
    if (req.cmd == CMD_ALLOC && rsp.status == ST_OK) live_blocks.push_back(rsp.block_addr);
    if (req.cmd == CMD_FREE && rsp.status == ST_OK) freed_blocks.push_back(req.free_addr);
    if (freed_blocks.size() > 16) freed_blocks.delete(0);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic alloc_req(int unsigned size, int unsigned align);
    in_t req;
    req = '0;
    req.cmd = CMD_ALLOC;
    req.size_bytes = size[DATA_W-1:0];
    req.align_bytes = align[DATA_W-1:0];
    req.free_addr = DATA_W'($urandom);
    send(req);
  endtask

  task automatic free_req(logic [DATA_W-1:0] addr);
    in_t req;
    req = '0;
    req.cmd = CMD_FREE;
    req.size_bytes = DATA_W'($urandom);
    req.align_bytes = DATA_W'($urandom);
    req.free_addr = addr;
    send(req);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_heap_cells(logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.rebuild(int'(value));
    cfg_we <= 1'b0;
    live_blocks.delete();
    freed_blocks.delete();
    n_configs++;
  endtask

  task automatic random_items(int count);
    int r, idx;
    int unsigned size, align;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 52 || (r < 90 && live_blocks.size() == 0)) begin
        size = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 200);
        case ($urandom_range(0, 3))
          0: align = 0;
          1: align = $urandom;
          default: align = 1 << $urandom_range(0, 9);
        endcase
        alloc_req(size, align);
      end else if (r < 90) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        free_req(live_blocks[idx]);
        live_blocks.delete(idx);
      end else if (r < 95 && freed_blocks.size() != 0) begin
        free_req(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
      end else begin
        free_req(DATA_W'($urandom));
      end
    end
  endtask

  initial begin
    #2000000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] settings[7];
    sb = new();
    sb.rebuild(CFG_RESET);
    n_items = 0;
    n_configs = 0;
    no_gaps = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // top block address, then its free through address zero
    alloc_req(0, 0);
    free_req(16'h0000);
    free_req(16'h0000);
    alloc_req(65535, 0);
    alloc_req(16, 65535);
    alloc_req(100, 256);
    alloc_req(1, 16);
    alloc_req(300, 1024);
    free_req(16'h0005);
    free_req(16'd16000);
    free_req(live_blocks[1]);
    free_req(live_blocks[0]);
    free_req(live_blocks[2]);
    free_req(live_blocks[0]);

    write_heap_cells(13'd2);
    alloc_req(16, 0);
    alloc_req(0, 0);
    free_req(16'h0010);
    free_req(16'h0010);
    free_req(16'h0020);
    free_req(16'hfff0);

    write_heap_cells(13'h1fff);
    alloc_req(65520, 0);
    alloc_req(0, 32768);
    random_items(300);

    settings = '{13'd0, 13'd64, 13'd300, 13'd4096, 13'd17, 13'd1000, 13'd2};
    foreach (settings[k]) begin
      write_heap_cells(settings[k]);
      random_items(200);
    end
    write_heap_cells(CFG_W'($urandom_range(2, 4096)));
    random_items(150);

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d transactions over %0d heap sizes, %0d results checked", n_items,
             n_configs + 1, sb.replies);
    $display("%0d allocations and %0d frees succeeded, %0d rejected", sb.ok_allocs,
             sb.ok_frees, sb.rejects);
    if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ aligned_free_list_heap_allocator_unit.f @@
sv/afl_pkg.sv
sv/afl_ram.sv
sv/afl_alu.sv
sv/aligned_free_list_heap_allocator_unit.sv
verif/tb_aligned_free_list_heap_allocator_unit.sv
